@@ hdl/brp_pkg.sv @@
// ----------------------------------------------------------------------------
// brp_pkg: shared types and constants for blockwise pivotal rounding
// Field widths, fixed-point constants, function codes and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brp_pkg;

  localparam int UNIT_W    = 16;
  localparam int BLK_W     = 8;
  localparam int PROB_FRAC = 16;
  localparam int PROB_W    = PROB_FRAC + 1;
  localparam int DRAW_W    = 16;
  localparam int TOL_W     = 13;

  // 1.0 and 0.5 in probability fixed point
  localparam logic [PROB_W-1:0] ONE_FX  = PROB_W'(1) << PROB_FRAC;
  localparam logic [PROB_W-1:0] HALF_FX = PROB_W'(1) << (PROB_FRAC - 1);

  // input function codes
  localparam logic FUNC_PRESENT = 1'b0;
  localparam logic FUNC_FLUSH   = 1'b1;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              decision;
    logic [PROB_W-1:0] residual;
    logic              is_frac;
    logic              last;
  } res_t;

  // value counts as settled when within tolerance of 0 or of 1.0
  function automatic logic settled(input logic [PROB_W-1:0] z,
                                   input logic [TOL_W-1:0]  tol);
    logic [PROB_W:0] s;
    s = {1'b0, z} + (PROB_W + 1)'(tol);
    return (z <= PROB_W'(tol)) || (s >= {1'b0, ONE_FX});
  endfunction

  function automatic res_t make_res(input logic [UNIT_W-1:0] unit,
                                    input logic [PROB_W-1:0] z,
                                    input logic              frac);
    res_t r;
    r.unit     = unit;
    r.decision = (z > HALF_FX);
    r.residual = z;
    r.is_frac  = frac;
    r.last     = 1'b0;
    return r;
  endfunction

endpackage

@@ hdl/brp_ifs.sv @@
// ----------------------------------------------------------------------------
// brp_ifs: valid/ready channels of blockwise pivotal rounding
// Input channel carries one unit or flush item, output channel one result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface brp_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [brp_pkg::UNIT_W-1:0]    unit_id;
  logic [brp_pkg::BLK_W-1:0]     block_id;
  logic [brp_pkg::PROB_W-1:0]    probability;
  logic [brp_pkg::DRAW_W-1:0]    random_draw;

  modport source(output valid, func, unit_id, block_id, probability, random_draw,
                 input ready);
  modport sink(input valid, func, unit_id, block_id, probability, random_draw,
               output ready);
endinterface

interface brp_out_if;
  logic                          valid;
  logic                          ready;
  logic [brp_pkg::UNIT_W-1:0]    out_unit;
  logic                          decision;
  logic [brp_pkg::PROB_W-1:0]    residual;
  logic                          is_fractional;
  logic                          last;

  modport source(output valid, out_unit, decision, residual, is_fractional, last,
                 input ready);
  modport sink(input valid, out_unit, decision, residual, is_fractional, last,
               output ready);
endinterface

@@ hdl/blockwise_pivotal_rounding.sv @@
// ----------------------------------------------------------------------------
// blockwise_pivotal_rounding: per-block ordered pivotal sampling, one pass
// Path: the input register (stage 1), then the result queue to the output.
// Throughput: one item per cycle while the result queue has room for two
//   results, set by the single read-modify-write of the open-unit table.
// Reset: synchronous, active low; all blocks empty at once, tolerance 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blockwise_pivotal_rounding #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  brp_in_if.sink                      in_ch,
  brp_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [brp_pkg::TOL_W-1:0]   cfg_wdata
);

  // Block ids are 8 bits, so at most 256 table rows are ever touched.
  localparam int NUM_IDS = 2 ** brp_pkg::BLK_W;
  localparam int DEPTH   = (MAX_BLOCKS > NUM_IDS) ? NUM_IDS : MAX_BLOCKS;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W  = brp_pkg::DRAW_W + brp_pkg::PROB_W + 1;
  localparam int FIFO_D  = 4;
  localparam int FIFO_AW = 2;
  localparam int CNT_W   = 3;

  typedef logic [IDX_W-1:0] map_t [NUM_IDS];

  typedef struct packed {
    logic [brp_pkg::UNIT_W-1:0] unit;
    logic [brp_pkg::PROB_W-1:0] value;
  } ent_t;

  // block id modulo MAX_BLOCKS, as a constant lookup table
  function automatic map_t build_map();
    map_t m;
    for (int i = 0; i < NUM_IDS; i++) begin
      m[i] = IDX_W'(i % MAX_BLOCKS);
    end
    return m;
  endfunction

  localparam map_t BLK_MAP = build_map();

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [brp_pkg::TOL_W-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Input register (stage 1) and table read
  // --------------------------------------------------------------------------
  logic                        in_acc;
  logic [IDX_W-1:0]            in_idx;
  logic                        commit;

  logic                        s1_vld_r, s1_vld_nxt;
  logic                        s1_func_r;
  logic [brp_pkg::UNIT_W-1:0]  s1_unit_r;
  logic [IDX_W-1:0]            s1_idx_r;
  logic [brp_pkg::PROB_W-1:0]  s1_prob_r;
  logic [brp_pkg::DRAW_W-1:0]  s1_draw_r;

  ent_t                        mem [DEPTH];
  ent_t                        mem_q_r;
  logic                        byp_hit_r;
  ent_t                        byp_ent_r;
  logic [DEPTH-1:0]            vld_r;

  logic                        wr_req, wr_en;
  ent_t                        wr_ent;
  logic                        vld_set, vld_clr;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_idx       = BLK_MAP[in_ch.block_id];
  assign in_ch.ready  = !s1_vld_r || commit;
  assign s1_vld_nxt   = in_acc ? 1'b1 : (commit ? 1'b0 : s1_vld_r);
  assign wr_en        = wr_req && commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= in_ch.func;
      s1_unit_r <= in_ch.unit_id;
      s1_idx_r  <= in_idx;
      s1_prob_r <= in_ch.probability;
      s1_draw_r <= in_ch.random_draw;
    end
  end

  // Open-unit table: one write (commit of stage 1), one registered read (accept).
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_idx_r] <= wr_ent;
    end
    if (in_acc) begin
      mem_q_r <= mem[in_idx];
    end
  end

  // Forward the entry being written this cycle to a following item of the
  // same block, whose table read would otherwise see the old row.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byp_hit_r <= wr_en && (s1_idx_r == in_idx);
      byp_ent_r <= wr_ent;
    end
  end

  // Occupancy per block; cleared at once by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (commit) begin
      if (vld_set) begin
        vld_r[s1_idx_r] <= 1'b1;
      end else if (vld_clr) begin
        vld_r[s1_idx_r] <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 compute: settle test, pairing bet, table update, results
  // --------------------------------------------------------------------------
  ent_t                        ent_cur;
  logic                        slot_vld;
  logic [brp_pkg::PROB_W-1:0]  zj, zi, du, dd, zi_n, zj_n, om_zi, om_zj;
  logic [brp_pkg::PROB_W:0]    dsum;
  logic [PROD_W-1:0]           lhs, rhs;
  logic                        go_up, fi, fj;
  brp_pkg::res_t               res0, res1, res_a, res_b;
  logic [1:0]                  n_res;

  assign ent_cur  = byp_hit_r ? byp_ent_r : mem_q_r;
  assign slot_vld = vld_r[s1_idx_r];
  assign zi       = ent_cur.value;
  // saturate probability above 1.0
  assign zj       = (s1_prob_r > brp_pkg::ONE_FX) ? brp_pkg::ONE_FX : s1_prob_r;
  assign om_zi    = brp_pkg::ONE_FX - zi;
  assign om_zj    = brp_pkg::ONE_FX - zj;
  assign du       = (om_zi < zj) ? om_zi : zj;
  assign dd       = (zi < om_zj) ? zi : om_zj;
  assign dsum     = {1'b0, du} + {1'b0, dd};

  // draw * (du + dd) < dd * 65536 picks the upward transfer, no division
  assign lhs   = {{(PROD_W - brp_pkg::DRAW_W){1'b0}}, s1_draw_r}
               * {{(PROD_W - brp_pkg::PROB_W - 1){1'b0}}, dsum};
  assign rhs   = {1'b0, dd, {brp_pkg::DRAW_W{1'b0}}};
  assign go_up = (lhs < rhs);
  assign zi_n  = go_up ? (zi + du) : (zi - dd);
  assign zj_n  = go_up ? (zj - du) : (zj + dd);
  assign fi    = !brp_pkg::settled(zi_n, tol_r);
  assign fj    = !brp_pkg::settled(zj_n, tol_r);

  always_comb begin
    res_a      = brp_pkg::make_res(ent_cur.unit, zi_n, 1'b0);
    res_b      = brp_pkg::make_res(s1_unit_r, zj_n, 1'b0);
    res0       = brp_pkg::make_res(s1_unit_r, zj, 1'b0);
    res1       = res_b;
    res1.last  = 1'b1;
    n_res      = 2'd0;
    wr_req     = 1'b0;
    wr_ent     = '{unit: s1_unit_r, value: zj};
    vld_set    = 1'b0;
    vld_clr    = 1'b0;
    if (s1_func_r == brp_pkg::FUNC_FLUSH) begin
      // emit and drop the block's leftover, if any
      if (slot_vld) begin
        res0      = brp_pkg::make_res(ent_cur.unit, zi, 1'b1);
        res0.last = 1'b1;
        n_res     = 2'd1;
        vld_clr   = 1'b1;
      end
    end else if (brp_pkg::settled(zj, tol_r)) begin
      res0.last = 1'b1;
      n_res     = 2'd1;
    end else if (!slot_vld) begin
      // open the block with this unit
      wr_req  = 1'b1;
      vld_set = 1'b1;
    end else begin
      if (fi) begin
        wr_req  = 1'b1;
        wr_ent  = '{unit: ent_cur.unit, value: zi_n};
        vld_set = 1'b1;
      end else if (fj) begin
        wr_req  = 1'b1;
        wr_ent  = '{unit: s1_unit_r, value: zj_n};
        vld_set = 1'b1;
      end else begin
        vld_clr = 1'b1;
      end
      // open unit first, then the new one
      if (!fi && !fj) begin
        res0  = res_a;
        n_res = 2'd2;
      end else if (!fi) begin
        res0      = res_a;
        res0.last = 1'b1;
        n_res     = 2'd1;
      end else if (!fj) begin
        res0      = res_b;
        res0.last = 1'b1;
        n_res     = 2'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result queue: takes up to two items a cycle, offers one
  // --------------------------------------------------------------------------
  brp_pkg::res_t               fifo_r [FIFO_D];
  logic [FIFO_AW-1:0]          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [1:0]                  push_n;
  logic                        pop;
  brp_pkg::res_t               head;

  // advance stage 1 only when the queue has room for two results
  assign commit  = s1_vld_r && (cnt_r <= CNT_W'(FIFO_D - 2));
  assign push_n  = commit ? n_res : 2'd0;
  assign pop     = out_ch.valid && out_ch.ready;
  assign wp_nxt  = wp_r + FIFO_AW'(push_n);
  assign rp_nxt  = rp_r + FIFO_AW'(pop);
  assign cnt_nxt = cnt_r + CNT_W'(push_n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wp_r] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_r[FIFO_AW'(wp_r + 1'b1)] <= res1;
    end
  end

  assign head                 = fifo_r[rp_r];
  assign out_ch.valid         = (cnt_r != '0);
  assign out_ch.out_unit      = head.unit;
  assign out_ch.decision      = head.decision;
  assign out_ch.residual      = head.residual;
  assign out_ch.is_fractional = head.is_frac;
  assign out_ch.last          = head.last;

endmodule

@@ tb/tb_blockwise_pivotal_rounding.sv @@
// ----------------------------------------------------------------------------
// tb_blockwise_pivotal_rounding: self-checking bench for blockwise pivotal rounding
// Drives unit and flush items under random idling on both channels, predicts
// each result from its own copy of the open-unit table, and checks every
// result item, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_blockwise_pivotal_rounding;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TICKS = 6;      // settling margin after draining
  localparam int ERR_PRINT_MAX = 100;
  localparam int HOT_BLOCKS   = 6;
  localparam longint unsigned ONE_VAL  = brp_pkg::ONE_FX;
  localparam longint unsigned HALF_VAL = brp_pkg::HALF_FX;
  localparam longint unsigned DRAW_ONE = 65536;

  // one pending input item; drain_first holds it back until nothing is expected
  typedef struct {
    logic                       func;
    logic [brp_pkg::UNIT_W-1:0] unit;
    logic [brp_pkg::BLK_W-1:0]  blk;
    logic [brp_pkg::PROB_W-1:0] prob;
    logic [brp_pkg::DRAW_W-1:0] draw;
    bit                         drain_first;
  } unit_item_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [brp_pkg::TOL_W-1:0] cfg_wdata;

  brp_in_if  in_ch ();
  brp_out_if out_ch ();

  blockwise_pivotal_rounding u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  unit_item_t    unit_q[$];      // items waiting to be driven
  brp_pkg::res_t result_q[$];    // predicted result items, oldest first

  // predictor copy of the open-unit table and tolerance
  bit                         open_valid [256];
  logic [brp_pkg::UNIT_W-1:0] open_unit  [256];
  longint unsigned            open_val   [256];
  logic [brp_pkg::TOL_W-1:0]  tol_copy;

  int         src_idle_pct;
  int         sink_idle_pct;
  int         error_count;
  int         cycle_count;
  logic       in_taken;
  bit         send_now;
  unit_item_t next_item;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Error reporting: one line per mismatch, printing capped, counting not
  // --------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    if (error_count < ERR_PRINT_MAX) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic bit is_settled(input longint unsigned z);
    return (z <= tol_copy) || (z + tol_copy >= ONE_VAL);
  endfunction

  task automatic push_result(input logic [brp_pkg::UNIT_W-1:0] unit,
                             input longint unsigned z, input logic frac);
    brp_pkg::res_t r;
    r.unit     = unit;
    r.decision = (z > HALF_VAL);
    r.residual = z[brp_pkg::PROB_W-1:0];
    r.is_frac  = frac;
    r.last     = 1'b0;
    result_q.insert(result_q.size(), r);
  endtask

  // Work out the results of one accepted item and advance the table copy.
  task automatic predict_rounding(input logic f, input logic [brp_pkg::UNIT_W-1:0] uid,
                                  input logic [brp_pkg::BLK_W-1:0] blk,
                                  input logic [brp_pkg::PROB_W-1:0] prob,
                                  input logic [brp_pkg::DRAW_W-1:0] draw);
    longint unsigned zi, zj, du, dd;
    logic [brp_pkg::UNIT_W-1:0] ui;
    bit fi, fj;
    int n_before;
    n_before = result_q.size();
    // saturate probabilities above 1.0
    zj = (prob > brp_pkg::ONE_FX) ? ONE_VAL : longint'(prob);

    if (f == brp_pkg::FUNC_FLUSH) begin
      // emit and clear the leftover; an empty block gives nothing
      if (open_valid[blk]) begin
        push_result(open_unit[blk], open_val[blk], 1'b1);
        open_valid[blk] = 1'b0;
      end
    end else if (is_settled(zj)) begin
      push_result(uid, zj, 1'b0);
    end else if (!open_valid[blk]) begin
      // first fractional unit opens the block silently
      open_valid[blk] = 1'b1;
      open_unit[blk]  = uid;
      open_val[blk]   = zj;
    end else begin
      zi = open_val[blk];
      ui = open_unit[blk];
      du = (ONE_VAL - zi < zj) ? ONE_VAL - zi : zj;
      dd = (zi < ONE_VAL - zj) ? zi : ONE_VAL - zj;
      // fair bet: up with probability dd/(du+dd), without dividing
      if (longint'(draw) * (du + dd) < dd * DRAW_ONE) begin
        zi = zi + du;
        zj = zj - du;
      end else begin
        zi = zi - dd;
        zj = zj + dd;
      end
      fi = !is_settled(zi);
      fj = !is_settled(zj);
      open_valid[blk] = 1'b0;
      if (fi) begin
        open_valid[blk] = 1'b1;
        open_val[blk]   = zi;
      end else begin
        push_result(ui, zi, 1'b0);
      end
      if (fj && !fi) begin
        open_valid[blk] = 1'b1;
        open_unit[blk]  = uid;
        open_val[blk]   = zj;
      end else if (!fj) begin
        push_result(uid, zj, 1'b0);
      end
    end
    // mark the final result of this item
    if (result_q.size() > n_before) begin
      result_q[result_q.size() - 1].last = 1'b1;
    end
  endtask

  task automatic check_result();
    brp_pkg::res_t want;
    if (result_q.size() == 0) begin
      flag_error($sformatf("unexpected result unit %h residual %h",
                           out_ch.out_unit, out_ch.residual));
      return;
    end
    want = result_q.pop_front();
    if (out_ch.out_unit !== want.unit || out_ch.decision !== want.decision ||
        out_ch.residual !== want.residual || out_ch.is_fractional !== want.is_frac ||
        out_ch.last !== want.last) begin
      flag_error($sformatf("got unit %h dec %b res %h frac %b last %b, want %h %b %h %b %b",
                           out_ch.out_unit, out_ch.decision, out_ch.residual,
                           out_ch.is_fractional, out_ch.last, want.unit,
                           want.decision, want.residual, want.is_frac, want.last));
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: sample both channels and the tolerance write at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (cfg_we) tol_copy = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        predict_rounding(in_ch.func, in_ch.unit_id, in_ch.block_id,
                         in_ch.probability, in_ch.random_draw);
      end
      if (out_ch.valid && out_ch.ready) check_result();
    end
  end

  // --------------------------------------------------------------------------
  // Driver: at the falling edge, hold an item until taken, then advance or idle
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      send_now = unit_q.size() != 0 && $urandom_range(99) >= src_idle_pct;
      // hold a drain-first item while results are still owed
      if (send_now && unit_q[0].drain_first && result_q.size() != 0) send_now = 1'b0;
      if (send_now) begin
        next_item = unit_q.pop_front();
        in_ch.func        <= next_item.func;
        in_ch.unit_id     <= next_item.unit;
        in_ch.block_id    <= next_item.blk;
        in_ch.probability <= next_item.prob;
        in_ch.random_draw <= next_item.draw;
      end
      in_ch.valid <= send_now;
    end
  end

  // receiver stalls at random
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_unit(input logic f, input logic [brp_pkg::UNIT_W-1:0] uid,
                            input logic [brp_pkg::BLK_W-1:0] blk,
                            input logic [brp_pkg::PROB_W-1:0] prob,
                            input logic [brp_pkg::DRAW_W-1:0] draw,
                            input bit drain_first);
    unit_item_t it;
    it.func        = f;
    it.unit        = uid;
    it.blk         = blk;
    it.prob        = prob;
    it.draw        = draw;
    it.drain_first = drain_first;
    unit_q.insert(unit_q.size(), it);
  endtask

  // Mostly fractional units over a few busy blocks so pairs form often; the
  // rest are flushes, stray blocks, settled and saturating probabilities.
  task automatic queue_random_units(input int count, input int tol);
    logic [brp_pkg::BLK_W-1:0]  hot [HOT_BLOCKS];
    logic [brp_pkg::BLK_W-1:0]  blk;
    logic [brp_pkg::PROB_W-1:0] prob;
    logic                       f;
    int k, sel;
    for (k = 0; k < HOT_BLOCKS; k++) hot[k] = brp_pkg::BLK_W'($urandom_range(255));
    for (k = 0; k < count; k++) begin
      blk = ($urandom_range(3) == 0) ? brp_pkg::BLK_W'($urandom_range(255))
                                     : hot[$urandom_range(HOT_BLOCKS - 1)];
      f = ($urandom_range(99) < 8) ? brp_pkg::FUNC_FLUSH : brp_pkg::FUNC_PRESENT;
      sel = $urandom_range(99);
      if (sel < 68)      prob = brp_pkg::PROB_W'($urandom_range(65535, 1));
      else if (sel < 76) prob = brp_pkg::PROB_W'($urandom_range(tol + 2, 0));
      else if (sel < 84) prob = brp_pkg::PROB_W'(65536 - $urandom_range(tol + 2, 0));
      else if (sel < 92) prob = $urandom_range(1) ? brp_pkg::ONE_FX : '0;
      else               prob = brp_pkg::PROB_W'($urandom_range(131071, 65537));
      queue_unit(f, brp_pkg::UNIT_W'($urandom_range(65535)), blk, prob,
                 brp_pkg::DRAW_W'($urandom_range(65535)), $urandom_range(49) == 0);
    end
  endtask

  // Wait for the queue to empty and every prediction to arrive, then let the
  // block settle before touching the tolerance. Sample at the rising edge, so
  // the driver's falling-edge updates have landed.
  task automatic wait_drained();
    do @(posedge clk);
    while (unit_q.size() != 0 || in_ch.valid || result_q.size() != 0);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic write_tolerance(input logic [brp_pkg::TOL_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int tol_mid;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.func        = brp_pkg::FUNC_PRESENT;
    in_ch.unit_id     = '0;
    in_ch.block_id    = '0;
    in_ch.probability = '0;
    in_ch.random_draw = '0;
    out_ch.ready      = 1'b0;
    tol_copy          = '0;
    error_count       = 0;
    cycle_count       = 0;
    src_idle_pct      = 36;
    sink_idle_pct     = 71;
    foreach (open_valid[i]) open_valid[i] = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed items, tolerance 0
    write_tolerance('0);
    queue_unit(brp_pkg::FUNC_PRESENT, 16'h0001, 8'd10, '0, '0, 0);       // zero: settled
    queue_unit(brp_pkg::FUNC_PRESENT, 16'hFFFF, 8'd10, brp_pkg::ONE_FX,
               16'hFFFF, 0);                                             // exactly 1.0
    queue_unit(brp_pkg::FUNC_PRESENT, 16'h0002, 8'd10, 17'h1FFFF, '0, 0); // saturates
    queue_unit(brp_pkg::FUNC_PRESENT, 16'h0003, 8'd10, 17'h10001, '0, 0);
    queue_unit(brp_pkg::FUNC_PRESENT, 16'h00A0, 8'd0, 17'h08000, '0, 0);  // opens block
    queue_unit(brp_pkg::FUNC_PRESENT, 16'h00A1, 8'd0, 17'h08000, '0, 0);  // up: both settle
    queue_unit(brp_pkg::FUNC_PRESENT, 16'h0B00, 8'd255, 17'h04000, '0, 0);
    queue_unit(brp_pkg::FUNC_PRESENT, 16'h0B01, 8'd255, 17'h04000,
               16'hFFFF, 0);                                             // down: one left
    queue_unit(brp_pkg::FUNC_FLUSH, 16'hDEAD, 8'd255, '0, '0, 0);        // fractional leftover
    queue_unit(brp_pkg::FUNC_FLUSH, 16'h1234, 8'd7, brp_pkg::ONE_FX,
               16'h8000, 0);                                             // empty block
    queue_unit(brp_pkg::FUNC_PRESENT, 16'hFFFF, 8'd3, 17'h00001, '0, 0); // smallest fraction
    queue_unit(brp_pkg::FUNC_PRESENT, 16'h7FFF, 8'd3, 17'h0FFFF,
               16'h0001, 0);                                             // largest fraction
    queue_unit(brp_pkg::FUNC_PRESENT, 16'h5555, 8'd3, 17'h03000, 16'hAAAA, 0);
    queue_unit(brp_pkg::FUNC_PRESENT, 16'hAAAA, 8'd3, 17'h03000,
               16'h1234, 1);                                             // drain first
    queue_unit(brp_pkg::FUNC_FLUSH, '0, 8'd3, 17'h1FFFF, 16'hFFFF, 0);
    queue_unit(brp_pkg::FUNC_PRESENT, 16'h8000, 8'hAA, 17'h0AAAA, 16'h5555, 0);
    queue_unit(brp_pkg::FUNC_PRESENT, 16'h0001, 8'h55, 17'h05555, 16'hAAAA, 0);
    queue_unit(brp_pkg::FUNC_PRESENT, 16'h0002, 8'hAA, 17'h0C000, 16'h0000, 0);
    queue_unit(brp_pkg::FUNC_FLUSH, 16'hFFFF, 8'h55, '0, '0, 0);
    queue_unit(brp_pkg::FUNC_FLUSH, 16'hFFFF, 8'hAA, '0, '0, 0);
    wait_drained();

    // tolerance 4096, sender lightly idle, receiver heavily stalled
    write_tolerance(brp_pkg::TOL_W'(4096));
    queue_random_units(160, 4096);
    wait_drained();

    // mid tolerance, idling swapped
    src_idle_pct  = 71;
    sink_idle_pct = 36;
    tol_mid = $urandom_range(4095, 1);
    write_tolerance(brp_pkg::TOL_W'(tol_mid));
    queue_random_units(160, tol_mid);
    wait_drained();

    // zero tolerance at full rate
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_tolerance('0);
    queue_random_units(100, 0);
    wait_drained();

    // all-ones tolerance, the largest the field holds
    write_tolerance('1);
    queue_random_units(30, 8191);
    wait_drained();

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
